>>> src/oled_page_framebuffer_core_defines.svh
// Assertion macros shared by the OLED page frame buffer RTL.
`ifndef OLED_PAGE_FRAMEBUFFER_CORE_DEFINES_SVH
`define OLED_PAGE_FRAMEBUFFER_CORE_DEFINES_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define OFB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante, outside reset.
`define OFB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ofb_pkg.sv
// Shared types and constants of the OLED page frame buffer.
package ofb_pkg;

    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Panel command bytes sent ahead of each page
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LO    = 8'h00;
    localparam logic [7:0] CMD_COL_HI    = 8'h10;

    typedef enum logic [1:0] {
        OP_POINT   = 2'd0,
        OP_FILL    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_REFRESH = 2'd3
    } op_t;

    // Row span inside one page byte, and the value to write
    typedef struct packed {
        logic [2:0] lo;
        logic [2:0] hi;
        logic       on;
    } merge_ctl_t;

endpackage

>>> src/ofb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ofb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/ofb_byte_unit.sv
// Shared read-modify-write unit: builds a row mask and merges it into a page byte.
module ofb_byte_unit (
    input  ofb_pkg::merge_ctl_t ctl,
    input  logic [7:0]          old_byte,
    output logic [7:0]          new_byte
);

    import ofb_pkg::*;

    logic [7:0] mask;

    // Row r of the page maps to bit 7-r; cover rows lo..hi
    always_comb
    begin
        mask = (8'hFF >> ctl.lo) & (8'hFF << (3'd7 - ctl.hi));
        if (ctl.on)
        begin
            new_byte = old_byte | mask;
        end
        else
        begin
            new_byte = old_byte & ~mask;
        end
    end

endmodule

>>> src/oled_page_framebuffer_core.sv
// Top level of the OLED page frame buffer: sequencer, frame store and beat output.
//
// Usage: drawing and refresh commands enter on the cmd channel (cmd_valid /
// cmd_stall); a transfer happens when cmd_valid is high and cmd_stall low.
// Panel beats leave on the beat channel (beat_valid / beat_stall), held in
// one output register so the sequencer can go on while a beat waits.
// The block takes one command at a time; cmd_stall is high while it works.
// Point: a read, then a merge and write of the one page byte.
// Fill: a read and a merged write for every page byte the clipped rectangle touches.
// Clear all: one store entry per cycle over the whole store depth of
// 2^(ceil(log2(COLUMNS)) + max(1, ceil(log2(PAGES)))) entries (1024 at the
// default size); the same pass runs after reset, so no command
// is taken until that pass ends once rst_n is released.
// Refresh: 1 command beat, then ceil(COLUMNS/8) data beats; each data beat
// is gathered through the single read port of the store (eight column
// reads, the registered read of the store, then a load of the output register).
// A refresh of a page past the panel produces no beats and leaves the block idle.
// When the receiver stalls, the beat holds and the sequencer waits before
// loading the next one; no beat is lost or repeated.
module oled_page_framebuffer_core #(
    parameter int COLUMNS = ofb_pkg::COLUMNS_DEF,
    parameter int PAGES   = ofb_pkg::PAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  op,
    input  logic [7:0]  x_start,
    input  logic [7:0]  y_start,
    input  logic [7:0]  x_end,
    input  logic [7:0]  y_end,
    input  logic        pixel_on,
    input  logic [2:0]  page_index,
    output logic        beat_valid,
    input  logic        beat_stall,
    output logic        is_data,
    output logic [63:0] beat_bytes,
    output logic        last_beat
);

    import ofb_pkg::*;

    `include "oled_page_framebuffer_core_defines.svh"

    localparam int ROWS       = PAGES * 8;
    localparam int CW         = $clog2(COLUMNS);
    localparam int PW         = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int AW         = CW + PW;
    localparam int DEPTH      = 1 << AW;
    localparam int DATA_BEATS = (COLUMNS + 7) / 8;
    localparam int CNTW       = $clog2(DATA_BEATS * 8 + 1);

    localparam logic [7:0]      X_MAX      = 8'(COLUMNS - 1);
    localparam logic [7:0]      Y_MAX      = 8'(ROWS - 1);
    localparam logic [PW-1:0]   PAGE_TOP   = PW'(PAGES - 1);
    localparam logic [4:0]      PAGE_LIM   = 5'(PAGES);
    localparam logic [CNTW-1:0] COL_LIM    = CNTW'(COLUMNS);
    localparam logic [CNTW-1:0] COL_END    = CNTW'(DATA_BEATS * 8);
    localparam logic [3:0]      GATHER_LEN = 4'd8;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_WR,
        S_CMD,
        S_GATHER,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_addr_reg, clr_addr_next;
    logic [7:0]      x_reg, x_next;
    logic [7:0]      x_last_reg, x_last_next;
    logic [PW-1:0]   g_reg, g_next;
    logic [PW-1:0]   g_first_reg, g_first_next;
    logic [PW-1:0]   g_last_reg, g_last_next;
    logic [2:0]      row_lo_reg, row_lo_next;
    logic [2:0]      row_hi_reg, row_hi_next;
    logic            on_reg, on_next;
    logic [PW-1:0]   page_reg, page_next;
    logic [CNTW-1:0] col_reg, col_next;
    logic            col_ok_reg, col_ok_next;
    logic [3:0]      gcnt_reg, gcnt_next;
    logic [63:0]     asm_reg, asm_next;
    logic            beat_valid_reg, beat_valid_next;
    logic            is_data_reg, is_data_next;
    logic [63:0]     beat_bytes_reg, beat_bytes_next;
    logic            last_beat_reg, last_beat_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;
    logic [7:0]      merged;
    merge_ctl_t      mctl;

    logic [7:0]      x_hi;
    logic [7:0]      y_hi;
    logic [7:0]      x_hi_clip;
    logic [7:0]      y_hi_clip;
    logic [4:0]      grp_lo;
    logic [4:0]      grp_hi;
    logic            draw_empty;
    logic            page_ok;
    logic            slot_free;
    logic [AW-1:0]   draw_addr;
    logic [AW-1:0]   gather_addr;
    logic [PW-1:0]   draw_page;

    // Clip the requested rectangle; a point is a one-pixel rectangle
    always_comb
    begin
        x_hi       = (op_t'(op) == OP_FILL) ? x_end : x_start;
        y_hi       = (op_t'(op) == OP_FILL) ? y_end : y_start;
        x_hi_clip  = (x_hi > X_MAX) ? X_MAX : x_hi;
        y_hi_clip  = (y_hi > Y_MAX) ? Y_MAX : y_hi;
        draw_empty = (x_start > x_hi_clip) || (y_start > y_hi_clip);
        grp_lo     = y_start[7:3];
        grp_hi     = y_hi_clip[7:3];
        page_ok    = ({2'b00, page_index} < PAGE_LIM);
    end

    // Store addresses: column-major, page in the low bits
    assign draw_page   = PAGE_TOP - g_reg;
    assign draw_addr   = {x_reg[CW-1:0], draw_page};
    assign gather_addr = {col_reg[CW-1:0], page_reg};
    assign slot_free   = !beat_valid_reg || !beat_stall;

    // Row span for the current byte
    always_comb
    begin
        mctl.lo = (g_reg == g_first_reg) ? row_lo_reg : 3'd0;
        mctl.hi = (g_reg == g_last_reg) ? row_hi_reg : 3'd7;
        mctl.on = on_reg;
    end

    ofb_byte_unit u_byte (
        .ctl      (mctl),
        .old_byte (ram_rdata),
        .new_byte (merged)
    );

    ofb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        x_next          = x_reg;
        x_last_next     = x_last_reg;
        g_next          = g_reg;
        g_first_next    = g_first_reg;
        g_last_next     = g_last_reg;
        row_lo_next     = row_lo_reg;
        row_hi_next     = row_hi_reg;
        on_next         = on_reg;
        page_next       = page_reg;
        col_next        = col_reg;
        col_ok_next     = col_ok_reg;
        gcnt_next       = gcnt_reg;
        asm_next        = asm_reg;
        beat_valid_next = beat_valid_reg;
        is_data_next    = is_data_reg;
        beat_bytes_next = beat_bytes_reg;
        last_beat_next  = last_beat_reg;
        ram_we          = 1'b0;
        ram_waddr       = draw_addr;
        ram_raddr       = draw_addr;
        ram_wdata       = merged;

        // Drop the held beat once it transfers
        if (beat_valid_reg && !beat_stall)
        begin
            beat_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                ram_waddr     = clr_addr_reg;
                ram_wdata     = 8'h00;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == {AW{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (op_t'(op))
                        OP_POINT, OP_FILL:
                        begin
                            x_next       = x_start;
                            x_last_next  = x_hi_clip;
                            g_next       = grp_lo[PW-1:0];
                            g_first_next = grp_lo[PW-1:0];
                            g_last_next  = grp_hi[PW-1:0];
                            row_lo_next  = y_start[2:0];
                            row_hi_next  = y_hi_clip[2:0];
                            on_next      = pixel_on;
                            if (!draw_empty)
                            begin
                                state_next = S_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = S_CLEAR;
                        end
                        OP_REFRESH:
                        begin
                            page_next = PW'(page_index);
                            if (page_ok)
                            begin
                                state_next = S_CMD;
                            end
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_WR;
            end
            S_WR:
            begin
                // Write the merged byte, then advance page then column
                ram_we = 1'b1;
                state_next = S_RD;
                if (g_reg == g_last_reg)
                begin
                    g_next = g_first_reg;
                    if (x_reg == x_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        x_next = x_reg + 8'd1;
                    end
                end
                else
                begin
                    g_next = g_reg + 1'b1;
                end
            end
            S_CMD:
            begin
                if (slot_free)
                begin
                    beat_valid_next = 1'b1;
                    is_data_next    = 1'b0;
                    last_beat_next  = 1'b0;
                    beat_bytes_next = {40'h0, CMD_COL_HI, CMD_COL_LO,
                                       CMD_PAGE_BASE + 8'(page_reg)};
                    col_next        = '0;
                    gcnt_next       = '0;
                    state_next      = S_GATHER;
                end
            end
            S_GATHER:
            begin
                // Issue eight column reads, shift each byte in when its registered read data returns
                ram_raddr = gather_addr;
                if (gcnt_reg != GATHER_LEN)
                begin
                    col_next    = col_reg + 1'b1;
                    col_ok_next = (col_reg < COL_LIM);
                end
                if (gcnt_reg != 4'd0)
                begin
                    asm_next = {(col_ok_reg ? ram_rdata : 8'h00), asm_reg[63:8]};
                end
                gcnt_next = gcnt_reg + 4'd1;
                if (gcnt_reg == GATHER_LEN)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    beat_valid_next = 1'b1;
                    is_data_next    = 1'b1;
                    beat_bytes_next = asm_reg;
                    last_beat_next  = (col_reg == COL_END);
                    gcnt_next       = '0;
                    if (col_reg == COL_END)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_GATHER;
                    end
                end
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            x_reg          <= '0;
            x_last_reg     <= '0;
            g_reg          <= '0;
            g_first_reg    <= '0;
            g_last_reg     <= '0;
            row_lo_reg     <= '0;
            row_hi_reg     <= '0;
            on_reg         <= 1'b0;
            page_reg       <= '0;
            col_reg        <= '0;
            col_ok_reg     <= 1'b0;
            gcnt_reg       <= '0;
            asm_reg        <= '0;
            beat_valid_reg <= 1'b0;
            is_data_reg    <= 1'b0;
            beat_bytes_reg <= '0;
            last_beat_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            x_reg          <= x_next;
            x_last_reg     <= x_last_next;
            g_reg          <= g_next;
            g_first_reg    <= g_first_next;
            g_last_reg     <= g_last_next;
            row_lo_reg     <= row_lo_next;
            row_hi_reg     <= row_hi_next;
            on_reg         <= on_next;
            page_reg       <= page_next;
            col_reg        <= col_next;
            col_ok_reg     <= col_ok_next;
            gcnt_reg       <= gcnt_next;
            asm_reg        <= asm_next;
            beat_valid_reg <= beat_valid_next;
            is_data_reg    <= is_data_next;
            beat_bytes_reg <= beat_bytes_next;
            last_beat_reg  <= last_beat_next;
        end
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign beat_valid = beat_valid_reg;
    assign is_data    = is_data_reg;
    assign beat_bytes = beat_bytes_reg;
    assign last_beat  = last_beat_reg;

    `OFB_ASSERT_IMP(a_store_write_state, clk, rst_n, ram_we,
        (state_reg == S_CLEAR) || (state_reg == S_WR), "store written outside clear or write")
    `OFB_ASSERT_IMP(a_last_is_data, clk, rst_n, beat_valid && last_beat, is_data,
        "last beat flagged on a command beat")
    `OFB_ASSERT_IMP(a_emit_after_gather, clk, rst_n, state_reg == S_EMIT,
        gcnt_reg == (GATHER_LEN + 4'd1), "beat emitted before all columns gathered")
    `OFB_ASSERT_NXT(a_cmd_beat_loads, clk, rst_n, (state_reg == S_CMD) && slot_free,
        beat_valid && !is_data && (state_reg == S_GATHER), "command beat not loaded")

endmodule
